[rtl/bcra_pkg.sv]
// Shared types and constants of the bitmap run allocator.
package bcra_pkg;

  // request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  // configuration register indexes
  localparam logic CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic CFG_FIRST_DATA   = 1'b1;

  localparam int unsigned TOTAL_W    = 13;
  localparam int unsigned BLK_FLD_W  = 12;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned CHUNK_BITS = 8;

  typedef struct packed {
    logic [1:0]           kind;
    logic [BLK_FLD_W-1:0] first_blk;
    logic [LEN_W-1:0]     run_length;
  } in_t;

  typedef struct packed {
    logic [BLK_FLD_W-1:0] alloc_start;
    logic                 success;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRD,
    ST_SCAN,
    ST_WRD,
    ST_WWR,
    ST_DONE
  } state_e;

endpackage

[rtl/bitmap_contiguous_run_allocator_core.sv]
// First-fit contiguous run allocator over a used/free block bitmap held in one RAM.
//
// Usage: requests arrive on in_valid_i/in_stall_o with in_data_i (kind, first_blk,
// run_length); each request yields exactly one result beat on out_valid_o/out_stall_i
// with out_data_o (alloc_start, success). Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must do so only while the block is idle, which
// the block itself does not enforce. Free and mark requests read and rewrite each
// map word the run touches. Allocate scans the map first-fit, 8 blocks per cycle out
// of a registered 64-bit RAM word, reading each word before its chunks are scanned;
// then the found run is written back as above. One request is in work at a time.
// After reset a clearing pass writes every map word to zero, during which no request
// is taken; configuration returns to 4096 total blocks and first data block 3.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls and a second result is ready, the block holds it until the
// first beat goes.
module bitmap_contiguous_run_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 4096,
  parameter int unsigned MAX_RUN    = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bcra_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bcra_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [bcra_pkg::TOTAL_W-1:0]        cfg_data_i
);
  import bcra_pkg::*;

  localparam int unsigned WORDS = NUM_BLOCKS / WORD_BITS;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BIW   = $clog2(NUM_BLOCKS);
  localparam int unsigned LW    = ((BIW > TOTAL_W) ? BIW : TOTAL_W) + 1;
  localparam logic [LW-1:0] NB  = LW'(NUM_BLOCKS);

  // map RAM
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic                 mem_re, mem_we;
  logic [WAW-1:0]       mem_ra, mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  state_e state_q, state_d;
  logic [TOTAL_W-1:0]   total_q;
  logic [BLK_FLD_W-1:0] fdb_q;
  logic [WAW:0]         clr_q, clr_d;
  logic [1:0]           kind_q, kind_d;
  logic [LEN_W-1:0]     len_q, len_d, cnt_q, cnt_d;
  logic [LW-1:0]        st_q, st_d, blk_q, blk_d, wend_q, wend_d;
  out_t                 res_q, res_d, out_q;
  logic                 out_valid_q;

  logic [LW-1:0]    limit, fdbx;
  logic [LEN_W-1:0] len_in;
  logic             out_load;

  assign limit  = (LW'(total_q) > NB) ? NB : LW'(total_q);
  assign fdbx   = LW'(fdb_q);
  assign len_in = (32'(in_data_i.run_length) > MAX_RUN) ? LEN_W'(MAX_RUN)
                                                        : in_data_i.run_length;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // chunk scan: 8 blocks of the held word
  logic             sc_found;
  logic [LW-1:0]    sc_start, sc_next;
  logic [LEN_W-1:0] sc_cnt;
  always_comb begin
    logic [LW-1:0]         b;
    logic [CHUNK_BITS-1:0] bits;
    logic                  used;
    sc_found = 1'b0;
    sc_start = st_q;
    sc_cnt   = cnt_q;
    bits     = rd_q[blk_q[5:3]*CHUNK_BITS +: CHUNK_BITS];
    for (int k = 0; k < CHUNK_BITS; k++) begin
      b    = blk_q + LW'(k);
      used = bits[k] || (b < fdbx) || (b >= limit);
      if (!sc_found) begin
        if (used) begin
          sc_cnt   = '0;
          sc_start = b + LW'(1);
        end else begin
          sc_cnt = sc_cnt + LEN_W'(1);
          if (sc_cnt == len_q) sc_found = 1'b1;
        end
      end
    end
    sc_next = blk_q + LW'(CHUNK_BITS);
  end

  // run mask over the held word
  logic [WORD_BITS-1:0] wmask;
  always_comb begin
    logic [LW-1:0] b;
    for (int k = 0; k < WORD_BITS; k++) begin
      b        = blk_q + LW'(k);
      wmask[k] = (b >= st_q) && (b < wend_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == (WAW+1)'(WORDS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_ALLOC) begin
            if (len_in == '0 || fdbx >= limit) state_d = ST_DONE;
            else state_d = ST_SRD;
          end else if (in_data_i.kind == KIND_FREE || in_data_i.kind == KIND_MARK) begin
            state_d = (len_in == '0) ? ST_DONE : ST_WRD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SRD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (sc_found) state_d = ST_WRD;
        else if (sc_next >= limit) state_d = ST_DONE;
        else if (sc_next[5:0] == '0) state_d = ST_SRD;
      end
      ST_WRD: begin
        if (blk_q >= NB || blk_q >= wend_q) state_d = ST_DONE;
        else state_d = ST_WWR;
      end
      ST_WWR: state_d = ST_WRD;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    clr_d  = clr_q;
    kind_d = kind_q;
    len_d  = len_q;
    cnt_d  = cnt_q;
    st_d   = st_q;
    blk_d  = blk_q;
    wend_d = wend_q;
    res_d  = res_q;
    mem_re = 1'b0;
    mem_ra = WAW'(blk_q >> 6);
    mem_we = 1'b0;
    mem_wa = WAW'(blk_q >> 6);
    mem_wd = (kind_q == KIND_FREE) ? (rd_q & ~wmask) : (rd_q | wmask);
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q[WAW-1:0];
        mem_wd = '0;
        clr_d  = clr_q + (WAW+1)'(1);
      end
      ST_IDLE: begin
        kind_d = in_data_i.kind;
        len_d  = len_in;
        cnt_d  = '0;
        res_d  = '0;
        if (in_data_i.kind == KIND_ALLOC) begin
          st_d  = fdbx;
          blk_d = fdbx & ~LW'(CHUNK_BITS - 1);
          if (len_in == '0 && fdbx <= limit) begin
            res_d.alloc_start = fdb_q;
            res_d.success     = 1'b1;
          end
        end else if (in_data_i.kind == KIND_FREE || in_data_i.kind == KIND_MARK) begin
          st_d          = LW'(in_data_i.first_blk);
          wend_d        = LW'(in_data_i.first_blk) + LW'(len_in);
          blk_d         = LW'(in_data_i.first_blk) & ~LW'(WORD_BITS - 1);
          res_d.success = 1'b1;
        end
      end
      ST_SRD: mem_re = 1'b1;
      ST_SCAN: begin
        if (sc_found) begin
          st_d              = sc_start;
          wend_d            = sc_start + LW'(len_q);
          blk_d             = sc_start & ~LW'(WORD_BITS - 1);
          res_d.alloc_start = sc_start[BLK_FLD_W-1:0];
          res_d.success     = 1'b1;
        end else begin
          st_d  = sc_start;
          cnt_d = sc_cnt;
          blk_d = sc_next;
        end
      end
      ST_WRD: mem_re = (blk_q < NB) && (blk_q < wend_q);
      ST_WWR: begin
        mem_we = 1'b1;
        blk_d  = blk_q + LW'(WORD_BITS);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      total_q     <= TOTAL_W'(4096);
      fdb_q       <= BLK_FLD_W'(3);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOTAL_BLOCKS) total_q <= cfg_data_i;
        else fdb_q <= cfg_data_i[BLK_FLD_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    len_q  <= len_d;
    cnt_q  <= cnt_d;
    st_q   <= st_d;
    blk_q  <= blk_d;
    wend_q <= wend_d;
    res_q  <= res_d;
    if (out_load) out_q <= res_q;
  end

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.success |-> out_data_o.alloc_start == '0)
    else $error("failed result carries a nonzero start");
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o)
    else $error("request taken during clearing pass");
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_WWR || state_q == ST_CLEAR))
    else $error("map write outside write or clear state");
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WWR |-> $past(state_q) == ST_WRD)
    else $error("map word written without a read");
`endif

endmodule

[bench/bitmap_contiguous_run_allocator_core_tb.sv]
// Self-checking testbench of the first-fit bitmap run allocator core.
`timescale 1ns / 100ps

module bitmap_contiguous_run_allocator_core_tb;
  import bcra_pkg::*;

  localparam int unsigned NUM_BLOCKS   = 4096;
  localparam int unsigned MAX_RUN      = 64;
  localparam logic [1:0]  KIND_INVALID = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned QUIET_ITEMS  = 60;

  // one row of the directed table: a register write or a request
  typedef struct {
    bit                 is_cfg;
    logic               idx;
    logic [TOTAL_W-1:0] val;
    in_t                rq;
    bit                 known;
    out_t               want;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_t                in_data;
  logic               out_valid;
  logic               out_stall;
  out_t               out_data;
  logic               cfg_we;
  logic               cfg_idx;
  logic [TOTAL_W-1:0] cfg_data;

  // predictor state
  bit                   block_used [NUM_BLOCKS];
  logic [TOTAL_W-1:0]   total_blocks;
  logic [BLK_FLD_W-1:0] first_data;

  out_t        pending_results[$];
  row_t        directed_rows[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          quiet;
  int unsigned stall_left;

  bitmap_contiguous_run_allocator_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // first-fit allocation, free and mark over the predictor's map
  function automatic out_t predict_request(in_t rq);
    int unsigned len;
    int unsigned lim;
    int unsigned s;
    bit          fits;
    out_t        r;
    r = '0;
    len = rq.run_length;
    if (len > MAX_RUN) len = MAX_RUN;
    case (rq.kind)
      KIND_ALLOC: begin
        lim = (total_blocks > NUM_BLOCKS) ? NUM_BLOCKS : total_blocks;
        for (s = first_data; s + len <= lim; s++) begin
          fits = 1'b1;
          for (int unsigned i = 0; i < len; i++) begin
            if (block_used[s + i]) begin
              fits = 1'b0;
              break;
            end
          end
          if (fits) begin
            for (int unsigned i = 0; i < len; i++) block_used[s + i] = 1'b1;
            r.alloc_start = s[BLK_FLD_W-1:0];
            r.success     = 1'b1;
            break;
          end
        end
      end
      KIND_FREE, KIND_MARK: begin
        for (int unsigned i = 0; i < len; i++) begin
          if (rq.first_blk + i < NUM_BLOCKS)
            block_used[rq.first_blk + i] = (rq.kind == KIND_MARK);
        end
        r.success = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // result side: random stall bursts, check every beat against the oldest expectation
  initial begin
    out_data_chk_loop: forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result beat: start %0d ok %0b",
                     out_data.alloc_start, out_data.success);
        end else begin
          out_t exp_r;
          exp_r = pending_results.pop_front();
          if (out_data.alloc_start !== exp_r.alloc_start ||
              out_data.success !== exp_r.success) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: expected start %0d ok %0b, got start %0d ok %0b",
                       exp_r.alloc_start, exp_r.success,
                       out_data.alloc_start, out_data.success);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // hand one request beat over, record its expected result on acceptance
  task automatic send_request(in_t rq, bit known, out_t want);
    out_t pred;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    pred = predict_request(rq);
    pending_results.push_back(known ? want : pred);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // wait for every result, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TOTAL_W-1:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_TOTAL_BLOCKS) total_blocks = val;
    else first_data = val[BLK_FLD_W-1:0];
  endtask

  task automatic add_req(logic [1:0] kind, int unsigned start, int unsigned len,
                         bit known, int unsigned w_start, bit w_ok);
    row_t r;
    r = '{default: '0};
    r.rq.kind        = kind;
    r.rq.first_blk   = start[BLK_FLD_W-1:0];
    r.rq.run_length  = len[LEN_W-1:0];
    r.known          = known;
    r.want.alloc_start = w_start[BLK_FLD_W-1:0];
    r.want.success     = w_ok;
    directed_rows.push_back(r);
  endtask

  task automatic add_cfg(logic idx, int unsigned val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val[TOTAL_W-1:0];
    directed_rows.push_back(r);
  endtask

  function automatic in_t random_request;
    in_t         rq;
    int unsigned lim;
    int unsigned pick;
    lim  = (total_blocks > NUM_BLOCKS) ? NUM_BLOCKS : total_blocks;
    pick = $urandom_range(0, 99);
    if (pick < 45)      rq.kind = KIND_ALLOC;
    else if (pick < 80) rq.kind = KIND_FREE;
    else if (pick < 94) rq.kind = KIND_MARK;
    else                rq.kind = KIND_INVALID;
    // frees and marks mostly land inside the usable area
    if ($urandom_range(0, 4) == 0 || lim == 0) rq.first_blk = BLK_FLD_W'($urandom);
    else rq.first_blk = BLK_FLD_W'($urandom_range(0, lim - 1));
    if ($urandom_range(0, 5) == 0) rq.run_length = LEN_W'($urandom_range(0, 127));
    else rq.run_length = LEN_W'($urandom_range(1, 16));
    return rq;
  endfunction

  // stimulus
  initial begin
    out_t nil;
    in_t  rq;
    nil          = '0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TOTAL_BLOCKS;
    cfg_data     = '0;
    quiet        = 1'b0;
    stall_left   = 0;
    mismatch_cnt = 0;
    total_blocks = 13'd4096;
    first_data   = 12'd3;
    foreach (block_used[i]) block_used[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults after reset
    add_req(KIND_ALLOC, 0, 1, 1, 3, 1);
    add_req(KIND_ALLOC, 0, 64, 1, 4, 1);
    add_req(KIND_ALLOC, 0, 0, 1, 3, 1);       // empty run marks nothing
    add_req(KIND_ALLOC, 4095, 127, 0, 0, 0);  // long run saturates
    add_req(KIND_MARK, 4095, 64, 1, 0, 1);    // beyond map
    add_req(KIND_FREE, 4095, 64, 1, 0, 1);
    add_req(KIND_INVALID, 4095, 127, 1, 0, 0);
    add_req(KIND_FREE, 0, 0, 1, 0, 1);
    add_req(KIND_FREE, 4, 64, 1, 0, 1);
    add_req(KIND_ALLOC, 0, 64, 0, 0, 0);
    add_req(KIND_MARK, 0, 127, 1, 0, 1);
    // zero-sized device, start at block zero
    add_cfg(CFG_TOTAL_BLOCKS, 0);
    add_cfg(CFG_FIRST_DATA, 0);
    add_req(KIND_ALLOC, 0, 1, 1, 0, 0);
    add_req(KIND_ALLOC, 0, 0, 1, 0, 1);
    add_cfg(CFG_TOTAL_BLOCKS, 8191);
    add_req(KIND_FREE, 0, 64, 1, 0, 1);
    add_req(KIND_ALLOC, 0, 1, 1, 0, 1);
    // top block of the map
    add_cfg(CFG_FIRST_DATA, 4095);
    add_req(KIND_ALLOC, 0, 1, 1, 4095, 1);
    add_req(KIND_ALLOC, 0, 2, 1, 0, 0);
    add_req(KIND_ALLOC, 0, 1, 1, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      else
        send_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].want);
    end

    // random: reconfigure every hundred requests
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 4))
          0:       write_reg(CFG_TOTAL_BLOCKS, TOTAL_W'($urandom_range(0, 8191)));
          1:       write_reg(CFG_TOTAL_BLOCKS, TOTAL_W'(4096));
          default: write_reg(CFG_TOTAL_BLOCKS, TOTAL_W'($urandom_range(64, 700)));
        endcase
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_FIRST_DATA, TOTAL_W'($urandom_range(0, 4095)));
          1:       write_reg(CFG_FIRST_DATA, TOTAL_W'(0));
          default: write_reg(CFG_FIRST_DATA, TOTAL_W'($urandom_range(0, 200)));
        endcase
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      rq = random_request();
      send_request(rq, 1'b0, nil);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
